/* rtl/twd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// twd_pkg
// Types and codes shared by the task/worker dispatcher and its checker.
// ----------------------------------------------------------------------------
package twd_pkg;

	localparam int WORKER_SLOTS   = 16;
	localparam int WORKER_BITS    = 4;
	localparam int IDLE_CNT_BITS  = 5;
	localparam int TASK_ID_BITS   = 16;
	localparam int TASK_DEPTH     = 64;
	localparam int PEND_CNT_BITS  = $clog2(TASK_DEPTH + 1);
	localparam int WANT_BITS      = 5;
	localparam int CFG_DATA_BITS  = 4;
	localparam int CFG_INDEX_BITS = 1;

	localparam logic [CFG_INDEX_BITS-1:0] CFG_BASE_WORKERS = 1'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_EXTRA    = 1'd1;

	localparam logic [CFG_DATA_BITS-1:0] BASE_RESET  = 4'd8;
	localparam logic [CFG_DATA_BITS-1:0] EXTRA_RESET = 4'd8;

	localparam logic [1:0] CMD_ADD    = 2'd0;
	localparam logic [1:0] CMD_PRIO   = 2'd1;
	localparam logic [1:0] CMD_FREED  = 2'd2;
	localparam logic [1:0] CMD_OBTAIN = 2'd3;

	localparam logic [2:0] EV_NONE     = 3'd0;
	localparam logic [2:0] EV_DISPATCH = 3'd1;
	localparam logic [2:0] EV_SPAWN    = 3'd2;
	localparam logic [2:0] EV_RETIRED  = 3'd3;
	localparam logic [2:0] EV_IDLED    = 3'd4;
	localparam logic [2:0] EV_RESERVED = 3'd5;
	localparam logic [2:0] EV_DROPPED  = 3'd6;

	typedef struct packed {
		logic [1:0]              command;
		logic [TASK_ID_BITS-1:0] task_tag;
		logic [WORKER_BITS-1:0]  worker_tag;
		logic [WANT_BITS-1:0]    want_count;
	} in_item_t;

	typedef struct packed {
		logic [2:0]               event_kind;
		logic [TASK_ID_BITS-1:0]  out_task;
		logic [WORKER_BITS-1:0]   out_worker;
		logic                     last_of_run;
		logic [IDLE_CNT_BITS-1:0] idle_count;
		logic [PEND_CNT_BITS-1:0] pending_count;
		logic                     all_busy;
		logic                     all_quiet;
	} out_item_t;

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

endpackage
`default_nettype wire

/* rtl/task_worker_dispatcher.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// task_worker_dispatcher
// Task deque and idle-worker deque held in two synchronous RAMs; each item is
// read at the transfer, then modified and written back in the execute state.
// Result: written to the output register from the execute state, which waits
//   while a stalled result is held; a new item is taken only when idle. Obtain
//   repeats execute for each reserved worker (one-read-per-cycle idle RAM port).
// Reset: base workers 0..7 idle, no task pending. Writing base_workers
//   reinitializes the deques and spawn counts at once (idle entries use per-entry valid bits).
// ----------------------------------------------------------------------------
module task_worker_dispatcher (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   in_valid,
	output logic                                  in_stall,
	input  wire  twd_pkg::in_item_t               in_data,
	output logic                                  out_valid,
	input  wire                                   out_stall,
	output twd_pkg::out_item_t                    out_data,
	input  wire                                   cfg_we,
	input  wire  [twd_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
	input  wire  [twd_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

	localparam int TASK_DEPTH = twd_pkg::TASK_DEPTH;
	localparam int TAW = $clog2(TASK_DEPTH);
	localparam int TFW = $clog2(TASK_DEPTH + 1);
	localparam int WB  = twd_pkg::WORKER_BITS;
	localparam int IB  = twd_pkg::IDLE_CNT_BITS;
	localparam int TB  = twd_pkg::TASK_ID_BITS;

	localparam logic [TAW-1:0] TASK_LAST = TAW'(TASK_DEPTH - 1);
	localparam logic [TFW-1:0] TASK_FULL = TFW'(TASK_DEPTH);

	twd_pkg::state_t state_q, state_n;

	logic [twd_pkg::CFG_DATA_BITS-1:0] base_q, max_extra_q;
	logic [TAW-1:0]                    task_head_q, task_head_n;
	logic [TFW-1:0]                    task_fill_q, task_fill_n;
	logic [WB-1:0]                     idle_head_q, idle_head_n;
	logic [IB-1:0]                     idle_fill_q, idle_fill_n;
	logic [WB-1:0]                     spawned_q, spawned_n;
	logic [WB-1:0]                     retired_q, retired_n;
	logic [twd_pkg::WORKER_SLOTS-1:0]  idle_vld_q;
	logic [IB-1:0]                     rem_q, rem_n;

	logic [1:0]      cmd_q;
	logic [TB-1:0]   tag_q;
	logic [WB-1:0]   wtag_q;

	logic [TB-1:0]   task_mem [TASK_DEPTH];
	logic [WB-1:0]   idle_mem [twd_pkg::WORKER_SLOTS];
	logic [TB-1:0]   task_rd_q;
	logic [WB-1:0]   idle_rd_q;
	logic [WB-1:0]   idle_rd_addr_q;
	logic            idle_rd_vld_q;

	logic            out_valid_q;
	twd_pkg::out_item_t out_data_q, res;

	logic            in_fire, exec_en, out_free, last;
	logic            task_we, idle_we, idle_re;
	logic [TAW-1:0]  task_waddr, task_tail, task_head_dec, task_head_inc;
	logic [TFW:0]    tail_sum;
	logic [WB-1:0]   idle_raddr, idle_front;
	logic            task_full;
	logic [IB-1:0]   want_n;
	logic [IB-1:0]   idle_cnt_out;

	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign in_fire   = in_valid && !in_stall;

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			twd_pkg::S_IDLE: if (in_fire) state_n = twd_pkg::S_EXEC;
			twd_pkg::S_EXEC: if (exec_en && last) state_n = twd_pkg::S_IDLE;
			default:         state_n = twd_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		in_stall = (state_q != twd_pkg::S_IDLE);
		exec_en  = (state_q == twd_pkg::S_EXEC) && out_free;
	end

	assign tail_sum      = (TFW+1)'(task_head_q) + (TFW+1)'(task_fill_q);
	assign task_tail     = (tail_sum >= (TFW+1)'(TASK_DEPTH)) ?
	                       TAW'(tail_sum - (TFW+1)'(TASK_DEPTH)) : TAW'(tail_sum);
	assign task_head_dec = (task_head_q == '0) ? TASK_LAST : task_head_q - 1'b1;
	assign task_head_inc = (task_head_q == TASK_LAST) ? '0 : task_head_q + 1'b1;
	assign task_full     = (task_fill_q >= TASK_FULL);
	assign want_n        = (in_data.want_count < idle_fill_q) ? in_data.want_count
	                                                          : idle_fill_q;

	assign idle_front = idle_rd_vld_q ? idle_rd_q :
	                    ((idle_rd_addr_q < base_q) ? idle_rd_addr_q : '0);

	always_comb begin
		res          = '0;
		last         = 1'b1;
		task_head_n  = task_head_q;
		task_fill_n  = task_fill_q;
		idle_head_n  = idle_head_q;
		idle_fill_n  = idle_fill_q;
		spawned_n    = spawned_q;
		retired_n    = retired_q;
		rem_n        = rem_q;
		task_we      = 1'b0;
		task_waddr   = task_tail;
		idle_we      = 1'b0;
		res.event_kind = twd_pkg::EV_NONE;
		unique case (cmd_q)
			twd_pkg::CMD_ADD: begin
				if (task_full) begin
					res.event_kind = twd_pkg::EV_DROPPED;
					res.out_task   = tag_q;
				end else begin
					task_we = 1'b1;
					if (idle_fill_q != '0) begin
						res.event_kind = twd_pkg::EV_DISPATCH;
						res.out_task   = (task_fill_q == '0) ? tag_q : task_rd_q;
						res.out_worker = idle_front;
						idle_head_n    = idle_head_q + 1'b1;
						idle_fill_n    = idle_fill_q - 1'b1;
						task_head_n    = task_head_inc;
					end else begin
						task_fill_n = task_fill_q + 1'b1;
					end
				end
			end
			twd_pkg::CMD_PRIO: begin
				if (idle_fill_q != '0) begin
					if (task_full) begin
						res.event_kind = twd_pkg::EV_DROPPED;
						res.out_task   = tag_q;
					end else begin
						res.event_kind = twd_pkg::EV_DISPATCH;
						res.out_task   = tag_q;
						res.out_worker = idle_front;
						idle_head_n    = idle_head_q + 1'b1;
						idle_fill_n    = idle_fill_q - 1'b1;
					end
				end else if (spawned_q < max_extra_q) begin
					res.event_kind = twd_pkg::EV_SPAWN;
					res.out_task   = tag_q;
					res.out_worker = WB'(base_q + spawned_q);
					spawned_n      = spawned_q + 1'b1;
				end else if (task_full) begin
					res.event_kind = twd_pkg::EV_DROPPED;
					res.out_task   = tag_q;
				end else begin
					task_we     = 1'b1;
					task_waddr  = task_head_dec;
					task_head_n = task_head_dec;
					task_fill_n = task_fill_q + 1'b1;
				end
			end
			twd_pkg::CMD_FREED: begin
				if (retired_q < spawned_q) begin
					res.event_kind = twd_pkg::EV_RETIRED;
					res.out_worker = wtag_q;
					retired_n      = retired_q + 1'b1;
				end else if (task_fill_q != '0) begin
					res.event_kind = twd_pkg::EV_DISPATCH;
					res.out_task   = task_rd_q;
					res.out_worker = wtag_q;
					task_head_n    = task_head_inc;
					task_fill_n    = task_fill_q - 1'b1;
				end else if (idle_fill_q < IB'(twd_pkg::WORKER_SLOTS)) begin
					res.event_kind = twd_pkg::EV_IDLED;
					res.out_worker = wtag_q;
					idle_we        = 1'b1;
					idle_head_n    = idle_head_q - 1'b1;
					idle_fill_n    = idle_fill_q + 1'b1;
				end
			end
			twd_pkg::CMD_OBTAIN: begin
				if (rem_q != '0) begin
					res.event_kind = twd_pkg::EV_RESERVED;
					res.out_worker = idle_front;
					idle_head_n    = idle_head_q + 1'b1;
					idle_fill_n    = idle_fill_q - 1'b1;
					rem_n          = rem_q - 1'b1;
					last           = (rem_q == IB'(1));
				end
			end
			default: ;
		endcase
		// obtain reports the fill left after the whole run
		idle_cnt_out      = (cmd_q == twd_pkg::CMD_OBTAIN) ? idle_fill_q - rem_q
		                                                   : idle_fill_n;
		res.last_of_run   = last;
		res.idle_count    = idle_cnt_out;
		res.pending_count = twd_pkg::PEND_CNT_BITS'(task_fill_n);
		res.all_busy      = (idle_cnt_out == '0);
		res.all_quiet     = (idle_cnt_out == IB'(base_q)) && (task_fill_n == '0);
	end

	assign idle_re    = in_fire || (exec_en && (cmd_q == twd_pkg::CMD_OBTAIN) &&
	                    (rem_q > IB'(1)));
	assign idle_raddr = in_fire ? idle_head_q : idle_head_q + 1'b1;

	always_ff @(posedge clk) begin
		if (exec_en && task_we) task_mem[task_waddr] <= tag_q;
		if (in_fire) task_rd_q <= task_mem[task_head_q];
	end

	always_ff @(posedge clk) begin
		if (exec_en && idle_we) idle_mem[idle_head_q - 1'b1] <= wtag_q;
		if (idle_re) begin
			idle_rd_q      <= idle_mem[idle_raddr];
			idle_rd_vld_q  <= idle_vld_q[idle_raddr];
			idle_rd_addr_q <= idle_raddr;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			cmd_q  <= in_data.command;
			tag_q  <= in_data.task_tag;
			wtag_q <= in_data.worker_tag;
		end
		if (exec_en) out_data_q <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= twd_pkg::S_IDLE;
			base_q      <= twd_pkg::BASE_RESET;
			max_extra_q <= twd_pkg::EXTRA_RESET;
			task_head_q <= '0;
			task_fill_q <= '0;
			idle_head_q <= '0;
			idle_fill_q <= IB'(twd_pkg::BASE_RESET);
			spawned_q   <= '0;
			retired_q   <= '0;
			idle_vld_q  <= '0;
			rem_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (exec_en) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (in_fire) rem_q <= want_n;
			if (exec_en) begin
				task_head_q <= task_head_n;
				task_fill_q <= task_fill_n;
				idle_head_q <= idle_head_n;
				idle_fill_q <= idle_fill_n;
				spawned_q   <= spawned_n;
				retired_q   <= retired_n;
				rem_q       <= rem_n;
				if (idle_we) idle_vld_q[idle_head_q - 1'b1] <= 1'b1;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					twd_pkg::CFG_BASE_WORKERS: begin
						base_q      <= cfg_data;
						task_head_q <= '0;
						task_fill_q <= '0;
						idle_head_q <= '0;
						idle_fill_q <= IB'(cfg_data);
						spawned_q   <= '0;
						retired_q   <= '0;
						idle_vld_q  <= '0;
					end
					twd_pkg::CFG_MAX_EXTRA: max_extra_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

endmodule
`default_nettype wire

/* rtl/twd_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// twd_checker
// Port-level checks for the task/worker dispatcher, bound into task_worker_dispatcher.
// ----------------------------------------------------------------------------
module twd_checker (
	input wire                     clk,
	input wire                     arst_n,
	input wire                     in_valid,
	input wire                     in_stall,
	input wire                     out_valid,
	input wire                     out_stall,
	input wire twd_pkg::out_item_t out_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second item taken while one is in flight");

	a_busy_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.all_busy == (out_data.idle_count == '0)))
		else $error("all_busy disagrees with idle_count");

	a_none_alone: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.event_kind == twd_pkg::EV_NONE) |-> out_data.last_of_run)
		else $error("empty event not the only result of its item");

endmodule

bind task_worker_dispatcher twd_checker u_twd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);
`default_nettype wire
